/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the integral image blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/iis_pkg.sv */
// ---------------------------------------------------------------------------
// Integral image package
// Payload types, register indexes and fixed widths of the integral image block.
// ---------------------------------------------------------------------------
`default_nettype none

package iis_pkg;

	localparam int PIX_W     = 8;
	localparam int COORD_W   = 13;
	localparam int SUM_W     = 32;
	localparam int CHAN_W    = 3;
	localparam int NUM_LANES = 4;
	localparam int EPOCH_W   = 16;
	localparam int REG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PADDED_MODE   = 2'd3;

	localparam logic [COORD_W-1:0] WIDTH_RST   = 13'd640;
	localparam logic [COORD_W-1:0] HEIGHT_RST  = 13'd480;
	localparam logic [CHAN_W-1:0]  CHANNEL_RST = 3'd1;
	localparam logic               PADDED_RST  = 1'b1;

	// Bit positions of the pending-result mask in the merge stage.
	localparam int PB_CORNER = 0;
	localparam int PB_TOP    = 1;
	localparam int PB_LEFT   = 2;
	localparam int PB_DATA   = 3;
	localparam int PEND_W    = 4;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_c0;
		logic [PIX_W-1:0] pixel_c1;
		logic [PIX_W-1:0] pixel_c2;
		logic [PIX_W-1:0] pixel_c3;
	} pix_t;

	typedef struct packed {
		logic [COORD_W-1:0]      out_row;
		logic [COORD_W-1:0]      out_col;
		logic signed [SUM_W-1:0] area_sum0;
		logic signed [SUM_W-1:0] area_sum1;
		logic signed [SUM_W-1:0] area_sum2;
		logic signed [SUM_W-1:0] area_sum3;
		logic                    last_of_run;
	} res_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] index;
		logic [COORD_W-1:0]   value;
	} cfg_t;

	// One entry of a lane's column store: frame tag and column sum.
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [SUM_W-1:0]   data;
	} entry_t;

	// Strobes from the control path to each lane.
	typedef struct packed {
		logic accept;
		logic fire;
		logic clr_en;
		logic row_start;
		logic active;
	} lane_ctrl_t;

	// Per-item information handed from stage 1 to the merge stage.
	typedef struct packed {
		logic [COORD_W-1:0] row_o;
		logic [COORD_W-1:0] col_o;
		logic               top;
		logic               left;
		logic               padded;
	} item_meta_t;

	typedef logic [NUM_LANES-1:0][SUM_W-1:0] lane_sums_t;

endpackage

`default_nettype wire

/* src/iis_if.sv */
// ---------------------------------------------------------------------------
// Integral image stream interface
// Valid/ready channel carrying one payload item per handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface iis_stream_if #(parameter type data_t = logic);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* src/iis_lane.sv */
// ---------------------------------------------------------------------------
// Integral image lane
// Row running sum and column store of one channel, with write forwarding.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iis_lane #(
	parameter int  DEPTH = 4096,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  iis_pkg::lane_ctrl_t       ctrl,
	input  wire [AW-1:0]              col,
	input  wire [AW-1:0]              clr_addr,
	input  wire [iis_pkg::PIX_W-1:0]  pixel,
	input  wire [iis_pkg::EPOCH_W-1:0] epoch,
	output logic [iis_pkg::SUM_W-1:0] sum
);
	import iis_pkg::*;

	entry_t             mem [DEPTH];
	logic [SUM_W-1:0]   rs_q;
	logic [SUM_W-1:0]   rs_next;
	entry_t             rd_s1;
	logic [AW-1:0]      addr_s1;
	logic [SUM_W-1:0]   rs_s1;
	logic               active_s1;
	logic [EPOCH_W-1:0] epoch_s1;
	logic               wr_valid_q;
	logic [AW-1:0]      wr_addr_q;
	entry_t             wr_ent_q;
	entry_t             cur_ent;
	logic [SUM_W-1:0]   base;
	logic [SUM_W-1:0]   col_sum;
	logic               do_write;

	// Row sum restarts at the first column, at zero for an idle channel; otherwise an idle channel holds its sum.
	always_comb begin
		if (ctrl.row_start) begin
			rs_next = ctrl.active ? SUM_W'(pixel) : '0;
		end else if (ctrl.active) begin
			rs_next = rs_q + SUM_W'(pixel);
		end else begin
			rs_next = rs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= '0;
		end else if (ctrl.accept) begin
			rs_q <= rs_next;
		end
	end

	// The store was read at the edge that took the item; a write at that same
	// edge is not in the read data, so it is taken from the forwarding register.
	always_comb begin
		cur_ent = (wr_valid_q && wr_addr_q == addr_s1) ? wr_ent_q : rd_s1;
		base    = (cur_ent.tag == epoch_s1) ? cur_ent.data : '0;
		col_sum = base + rs_s1;
	end

	assign sum      = active_s1 ? col_sum : '0;
	assign do_write = ctrl.fire && active_s1;

	always_ff @(posedge clk) begin
		if (ctrl.clr_en) begin
			mem[clr_addr] <= '0;
		end else if (do_write) begin
			mem[addr_s1] <= '{tag: epoch_s1, data: col_sum};
		end
		if (ctrl.accept) begin
			rd_s1     <= mem[col];
			addr_s1   <= col;
			rs_s1     <= rs_next;
			active_s1 <= ctrl.active;
			epoch_s1  <= epoch;
		end
		if (do_write) begin
			wr_addr_q <= addr_s1;
			wr_ent_q  <= '{tag: epoch_s1, data: col_sum};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (ctrl.clr_en) begin
			wr_valid_q <= 1'b0;
		end else if (do_write) begin
			wr_valid_q <= 1'b1;
		end
	end

	`IIS_ASSERT_NOW(a_clr_idle, clk, arst_n, ctrl.clr_en, !ctrl.accept && !ctrl.fire, "lane busy during clear")
	`IIS_ASSERT_NEXT(a_row_start_idle, clk, arst_n, ctrl.accept && ctrl.row_start && !ctrl.active, rs_q == '0, "idle row sum not cleared")
	`IIS_ASSERT_NEXT(a_fwd_tag, clk, arst_n, do_write, wr_valid_q && wr_addr_q == $past(addr_s1), "forwarding register not updated")

endmodule

`default_nettype wire

/* src/iis_merge.sv */
// ---------------------------------------------------------------------------
// Integral image merge stage
// Combines the lane sums into result items and emits border results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iis_merge (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  iis_pkg::item_meta_t  meta,
	input  iis_pkg::lane_sums_t  sums,
	output logic                 take,
	iis_stream_if.source         res
);
	import iis_pkg::*;

	logic [PEND_W-1:0] pend_q;
	item_meta_t        meta_q;
	lane_sums_t        sums_q;
	logic              last;
	logic              res_fire;

	assign res.valid = |pend_q;
	assign last      = (pend_q == (PEND_W'(1) << PB_DATA));
	assign res_fire  = res.valid && res.ready;
	assign take      = !res.valid || (res_fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q[PB_CORNER] <= meta.padded && meta.top && meta.left;
			pend_q[PB_TOP]    <= meta.padded && meta.top;
			pend_q[PB_LEFT]   <= meta.padded && meta.left;
			pend_q[PB_DATA]   <= 1'b1;
		end else if (res_fire) begin
			// Drop the lowest pending result.
			pend_q <= pend_q & (pend_q - PEND_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			meta_q <= meta;
			sums_q <= sums;
		end
	end

	always_comb begin
		res.data = '0;
		priority if (pend_q[PB_CORNER]) begin
			res.data.out_row = '0;
			res.data.out_col = '0;
		end else if (pend_q[PB_TOP]) begin
			res.data.out_row = '0;
			res.data.out_col = meta_q.col_o;
		end else if (pend_q[PB_LEFT]) begin
			res.data.out_row = meta_q.row_o;
			res.data.out_col = '0;
		end else begin
			res.data.out_row     = meta_q.row_o;
			res.data.out_col     = meta_q.col_o;
			res.data.area_sum0   = $signed(sums_q[0]);
			res.data.area_sum1   = $signed(sums_q[1]);
			res.data.area_sum2   = $signed(sums_q[2]);
			res.data.area_sum3   = $signed(sums_q[3]);
			res.data.last_of_run = 1'b1;
		end
	end

	`IIS_ASSERT_NOW(a_load_free, clk, arst_n, load, take, "merge loaded while busy")
	`IIS_ASSERT_NOW(a_border_zero, clk, arst_n, res.valid && !res.data.last_of_run, res.data.area_sum0 == 0 && res.data.area_sum3 == 0, "border result not zero")
	`IIS_ASSERT_NEXT(a_run_holds, clk, arst_n, res_fire && !last, res.valid, "run of results broken")

endmodule

`default_nettype wire

/* src/integral_image_stream.sv */
// ---------------------------------------------------------------------------
// Integral image stream
// Streaming summed-area table over up to four 8-bit channels per pixel.
// ---------------------------------------------------------------------------
//
//   channel | direction | payload                              | item
//   --------+-----------+--------------------------------------+-----------------
//   pix     | in        | pixel_c0 .. pixel_c3                 | one raster pixel
//   res     | out       | out_row, out_col, area_sum0..3, last | one table value
//   cfg     | in        | index, value                         | register write
//
// One pixel is taken per clock while results flow. Interior pixels give one
// result each; in padded mode a pixel of the top row or of the left column
// gives two and the first pixel of a frame four. The merge stage has a single
// result port, so the pixels after them wait until those results have left.
// A pixel passes stage 1, which reads the column store, adds and writes back,
// then the merge stage, which registers and sequences the results.
// After reset all MAX_WIDTH entries of the column stores are swept to zero;
// pix.ready stays low during the sweep while cfg writes are taken.
// A stalled res side holds the merge stage, then stage 1, then drops pix.ready.
//
// Each channel is a lane with its own row sum and column store. Store entries
// carry the frame count of their last write, so an entry from an earlier frame
// reads as zero and the store needs no clearing at each frame start. The
// frame count lasts for 65535 frames; when it runs out, the first pixel of the
// next frame waits until stage 1 is empty and a fresh sweep has cleared all
// MAX_WIDTH entries of the stores, and the count starts again.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module integral_image_stream #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_HEIGHT   = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  wire          clk,
	input  wire          arst_n,
	iis_stream_if.sink   pix,
	iis_stream_if.source res,
	iis_stream_if.sink   cfg
);
	import iis_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Configuration registers.
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               padded_q;

	logic [COORD_W-1:0] w_eff;
	logic [COORD_W-1:0] h_eff;
	logic [CHAN_W-1:0]  cn_eff;

	// Position, frame count and store sweep.
	logic [CW-1:0]      c_q;
	logic [RW-1:0]      r_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [EPOCH_W-1:0] epoch_use;
	logic               clr_busy_q;
	logic [CW-1:0]      clr_addr_q;
	logic               wrap_hold;
	logic               wrap_start;

	logic [CW:0]        c_inc;
	logic [RW:0]        r_inc;
	logic [CW-1:0]      c_next;
	logic [RW-1:0]      r_next;

	logic               accept;
	logic               s1_valid_q;
	logic               s1_fire;
	item_meta_t         meta_s1;
	item_meta_t         meta_now;
	logic               mrg_take;
	lane_sums_t         lane_sum;
	logic [PIX_W-1:0]   pix_val [NUM_LANES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			chan_q   <= CHANNEL_RST;
			padded_q <= PADDED_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				REG_IMAGE_WIDTH:   width_q  <= cfg.data.value;
				REG_IMAGE_HEIGHT:  height_q <= cfg.data.value;
				REG_CHANNEL_COUNT: chan_q   <= cfg.data.value[CHAN_W-1:0];
				REG_PADDED_MODE:   padded_q <= cfg.data.value[0];
			endcase
		end
	end

	// Zero counts act as one, counts beyond the build limits saturate.
	always_comb begin
		if (width_q == '0) begin
			w_eff = COORD_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = COORD_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = COORD_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = COORD_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		if (chan_q == '0) begin
			cn_eff = CHAN_W'(1);
		end else if (32'(chan_q) > MAX_CHANNELS) begin
			cn_eff = CHAN_W'(MAX_CHANNELS);
		end else begin
			cn_eff = chan_q;
		end
	end

	// Raster position. After a change of size the position wraps as soon as
	// it reaches or passes the new row end or frame end.
	always_comb begin
		c_inc = {1'b0, c_q} + (CW + 1)'(1);
		r_inc = {1'b0, r_q} + (RW + 1)'(1);
		if (32'(c_inc) >= 32'(w_eff)) begin
			c_next = '0;
			r_next = (32'(r_inc) >= 32'(h_eff)) ? '0 : r_inc[RW-1:0];
		end else if (32'(r_q) >= 32'(h_eff)) begin
			c_next = '0;
			r_next = '0;
		end else begin
			c_next = c_inc[CW-1:0];
			r_next = r_q;
		end
	end

	// A frame that would need a frame count beyond the last one waits for a
	// fresh sweep; the sweep starts once stage 1 has written back.
	assign wrap_hold  = (r_q == '0) && (c_q == '0) && (epoch_q == '1);
	assign wrap_start = wrap_hold && !s1_valid_q && !clr_busy_q;

	assign pix.ready = !clr_busy_q && !wrap_hold && (!s1_valid_q || mrg_take);
	assign accept    = pix.valid && pix.ready;
	assign s1_fire   = s1_valid_q && mrg_take;

	// A new frame count starts with the first pixel of every frame.
	assign epoch_use = (r_q == '0 && c_q == '0) ? epoch_q + EPOCH_W'(1) : epoch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q        <= '0;
			r_q        <= '0;
			epoch_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				c_q     <= c_next;
				r_q     <= r_next;
				epoch_q <= epoch_use;
			end else if (wrap_start) begin
				epoch_q <= '0;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end else if (wrap_start) begin
			clr_busy_q <= 1'b1;
		end
	end

	// Coordinates of the data result; padding shifts them by one each way.
	always_comb begin
		meta_now.top    = (r_q == '0);
		meta_now.left   = (c_q == '0);
		meta_now.padded = padded_q;
		meta_now.row_o  = padded_q ? COORD_W'(r_q) + COORD_W'(1) : COORD_W'(r_q);
		meta_now.col_o  = padded_q ? COORD_W'(c_q) + COORD_W'(1) : COORD_W'(c_q);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_now;
		end
	end

	assign pix_val[0] = pix.data.pixel_c0;
	assign pix_val[1] = pix.data.pixel_c1;
	assign pix_val[2] = pix.data.pixel_c2;
	assign pix_val[3] = pix.data.pixel_c3;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_ch
		if (i < MAX_CHANNELS) begin : g_lane
			lane_ctrl_t lctl;

			always_comb begin
				lctl.accept    = accept;
				lctl.fire      = s1_fire;
				lctl.clr_en    = clr_busy_q;
				lctl.row_start = (c_q == '0);
				lctl.active    = (CHAN_W'(i) < cn_eff);
			end

			iis_lane #(
				.DEPTH (MAX_WIDTH)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (lctl),
				.col      (c_q),
				.clr_addr (clr_addr_q),
				.pixel    (pix_val[i]),
				.epoch    (epoch_use),
				.sum      (lane_sum[i])
			);
		end else begin : g_none
			assign lane_sum[i] = '0;
		end
	end

	iis_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (s1_fire),
		.meta   (meta_s1),
		.sums   (lane_sum),
		.take   (mrg_take),
		.res    (res)
	);

	`IIS_ASSERT_NOW(a_no_pix_in_clear, clk, arst_n, clr_busy_q, !pix.ready, "pixel taken during store sweep")
	`IIS_ASSERT_NEXT(a_accept_fills, clk, arst_n, accept, s1_valid_q, "accepted item not in stage 1")
	`IIS_ASSERT_NEXT(a_s1_holds, clk, arst_n, s1_valid_q && !mrg_take, s1_valid_q && $stable(meta_s1), "stalled stage 1 lost its item")

endmodule

`default_nettype wire
